// File: src/ctlex_pkg.sv
`timescale 1ns / 1ps

package ctlex_pkg;

	// Default word store depth
	localparam int MAX_TOKEN_LEN_DEF = 32;

	// Word length field, wide enough for a store of up to 63 bytes
	localparam int LEN_W = 6;

	// Result cap per source byte
	localparam int MAX_RESULTS = 35;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// Command queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Token classes
	localparam logic [2:0] CLS_SEP     = 3'd0;
	localparam logic [2:0] CLS_KEYWORD = 3'd1;
	localparam logic [2:0] CLS_PAREN   = 3'd2;
	localparam logic [2:0] CLS_BRACE   = 3'd3;
	localparam logic [2:0] CLS_OPER    = 3'd4;
	localparam logic [2:0] CLS_NUMBER  = 3'd5;
	localparam logic [2:0] CLS_IDENT   = 3'd6;
	localparam logic [2:0] CLS_UNKNOWN = 3'd7;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Class flag bits: 0..7 keyword candidates, then number, identifier, op start
	localparam int NUM_KW      = 8;
	localparam int FLAG_NUMBER = 8;
	localparam int FLAG_IDENT  = 9;
	localparam int FLAG_OPSTRT = 10;
	localparam int FLAGS_W     = 11;

	typedef logic [FLAGS_W-1:0] flags_t;

	// Keyword text, right-justified, and lengths
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'("int"), 48'("char"), 48'("float"), 48'("double"),
		48'("if"), 48'("else"), 48'("while"), 48'("for")
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd4, 3'd5, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3
	};

	// One source byte's worth of work for the back end
	typedef struct packed {
		logic             pre_valid;    // held operator is emitted first
		logic [7:0]       pre_char;
		logic             pair;         // byte completes a two-char operator
		logic [7:0]       in_char;
		logic             app_valid;    // byte goes into the word store
		logic [LEN_W-1:0] app_idx;
		logic             flush_valid;  // a word is emitted
		logic [2:0]       flush_cls;
		logic [LEN_W-1:0] flush_len;
		logic             single_valid; // byte is a token of its own
		logic [2:0]       single_cls;
		logic             post_valid;   // operator held by the final byte
	} rec_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR) || (c == CH_NUL);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
			(c == CH_UNDER);
	endfunction

	function automatic logic is_op_start(logic [7:0] c);
		logic r;
		unique case (c) inside
			CH_LT, CH_GT, CH_BANG, CH_PLUS, CH_MINUS, CH_EQ, CH_STAR, CH_SLASH,
			CH_PCT: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// {is single-char token, class}
	function automatic logic [3:0] single_class(logic [7:0] c);
		logic [3:0] r;
		unique case (c) inside
			CH_SEMI, CH_COMMA, CH_QUOTE:       r = {1'b1, CLS_SEP};
			CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK: r = {1'b1, CLS_PAREN};
			CH_LBRACE, CH_RBRACE:              r = {1'b1, CLS_BRACE};
			default:                           r = {1'b0, CLS_SEP};
		endcase
		return r;
	endfunction

	// Keyword k has byte c at position i
	function automatic logic kw_hit(int k, logic [LEN_W-1:0] i, logic [7:0] c);
		int base;
		base = 8 * (int'(KW_LEN[k]) - 1 - int'(i));
		if (base < 0)
			return 1'b0;
		return KW_TEXT[k][base +: 8] == c;
	endfunction

	// Class of a finished word
	function automatic logic [2:0] word_class(flags_t flags, logic [1:0] dots,
			logic ovf, logic [LEN_W-1:0] len);
		logic kw;
		logic [2:0] cls;
		kw = 1'b0;
		for (int k = 0; k < NUM_KW; k++)
			if (flags[k] && len == LEN_W'(KW_LEN[k]))
				kw = 1'b1;
		if (ovf)
			cls = CLS_UNKNOWN;
		else if (kw)
			cls = CLS_KEYWORD;
		else if (flags[FLAG_OPSTRT])
			cls = CLS_OPER;
		else if (flags[FLAG_NUMBER] && dots <= 2'd1)
			cls = CLS_NUMBER;
		else if (flags[FLAG_IDENT])
			cls = CLS_IDENT;
		else
			cls = CLS_UNKNOWN;
		return cls;
	endfunction

endpackage

// File: src/ctlex_char_if.sv
`timescale 1ns / 1ps

interface ctlex_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_char;
	logic       end_of_text;

	modport source(output valid, source_char, end_of_text, input ready);
	modport sink(input valid, source_char, end_of_text, output ready);
endinterface

// File: src/ctlex_token_if.sv
`timescale 1ns / 1ps

interface ctlex_token_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_class;
	logic [7:0] token_char;
	logic       token_end;
	logic       run_end;

	modport source(output valid, token_class, token_char, token_end, run_end, input ready);
	modport sink(input valid, token_class, token_char, token_end, run_end, output ready);
endinterface

// File: src/ctlex_front.sv
`timescale 1ns / 1ps

module ctlex_front #(
	parameter int MAX_TOKEN_LEN = ctlex_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ctlex_char_if.sink        char_in,
	output logic              push,
	output ctlex_pkg::rec_t   push_rec,
	input  logic              full
);

	// Word tracking state
	logic [ctlex_pkg::LEN_W-1:0] len_q, len_d;
	logic                        ovf_q, ovf_d;
	logic [1:0]                  dots_q, dots_d;
	ctlex_pkg::flags_t           flags_q, flags_d;
	logic                        pend_v_q, pend_v_d;
	logic [7:0]                  pend_c_q, pend_c_d;

	logic [7:0] c;
	logic       last;
	logic       pair;
	logic [3:0] sgl;
	logic       take;

	assign c    = char_in.source_char;
	assign last = char_in.end_of_text;
	assign sgl  = ctlex_pkg::single_class(c);
	assign pair = (c == ctlex_pkg::CH_EQ) ||
		(c == ctlex_pkg::CH_PLUS && pend_c_q == ctlex_pkg::CH_PLUS) ||
		(c == ctlex_pkg::CH_MINUS && pend_c_q == ctlex_pkg::CH_MINUS);

	assign char_in.ready = !full;
	assign take          = char_in.valid && !full;
	assign push          = take;

	// Classify the byte and build its command record
	always_comb begin
		push_rec          = '0;
		push_rec.in_char  = c;
		push_rec.pre_valid = pend_v_q;
		push_rec.pre_char = pend_c_q;
		push_rec.pair     = pend_v_q && pair;
		len_d    = len_q;
		ovf_d    = ovf_q;
		dots_d   = dots_q;
		flags_d  = flags_q;
		pend_v_d = 1'b0;
		pend_c_d = 8'h00;

		if (!(pend_v_q && pair)) begin
			if (ctlex_pkg::is_space(c) || sgl[3] || ctlex_pkg::is_op_start(c)) begin
				// word ends here
				if (len_q != '0) begin
					push_rec.flush_valid = 1'b1;
					push_rec.flush_cls   = ctlex_pkg::word_class(flags_q, dots_q, ovf_q, len_q);
					push_rec.flush_len   = len_q;
					len_d   = '0;
					ovf_d   = 1'b0;
					dots_d  = 2'd0;
					flags_d = '1;
				end
				if (sgl[3]) begin
					push_rec.single_valid = 1'b1;
					push_rec.single_cls   = sgl[2:0];
				end
				if (ctlex_pkg::is_op_start(c)) begin
					pend_v_d = 1'b1;
					pend_c_d = c;
				end
			end else if (ovf_q || len_q >= ctlex_pkg::LEN_W'(MAX_TOKEN_LEN)) begin
				ovf_d = 1'b1;
			end else begin
				// extend the word and narrow down its class
				push_rec.app_valid = 1'b1;
				push_rec.app_idx   = len_q;
				for (int k = 0; k < ctlex_pkg::NUM_KW; k++)
					if (!ctlex_pkg::kw_hit(k, len_q, c))
						flags_d[k] = 1'b0;
				if (c == ctlex_pkg::CH_DOT) begin
					if (dots_q != 2'd2)
						dots_d = dots_q + 2'd1;
				end else if (!ctlex_pkg::is_digit(c)) begin
					flags_d[ctlex_pkg::FLAG_NUMBER] = 1'b0;
				end
				if (len_q == '0) begin
					if (!ctlex_pkg::is_alpha(c))
						flags_d[ctlex_pkg::FLAG_IDENT] = 1'b0;
					if (!(c == ctlex_pkg::CH_AMP || c == ctlex_pkg::CH_BAR ||
							c == ctlex_pkg::CH_CARET))
						flags_d[ctlex_pkg::FLAG_OPSTRT] = 1'b0;
				end else if (!ctlex_pkg::is_alpha(c) && !ctlex_pkg::is_digit(c)) begin
					flags_d[ctlex_pkg::FLAG_IDENT] = 1'b0;
				end
				len_d = len_q + ctlex_pkg::LEN_W'(1);
			end
		end

		// final byte: release held operator, then the open word
		if (last) begin
			if (pend_v_d) begin
				push_rec.post_valid = 1'b1;
				pend_v_d = 1'b0;
				pend_c_d = 8'h00;
			end
			if (len_d != '0) begin
				push_rec.flush_valid = 1'b1;
				push_rec.flush_cls   = ctlex_pkg::word_class(flags_d, dots_d, ovf_d, len_d);
				push_rec.flush_len   = len_d;
				len_d   = '0;
				ovf_d   = 1'b0;
				dots_d  = 2'd0;
				flags_d = '1;
			end
		end
	end

	// State update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			dots_q   <= 2'd0;
			flags_q  <= '1;
			pend_v_q <= 1'b0;
			pend_c_q <= 8'h00;
		end else if (take) begin
			len_q    <= len_d;
			ovf_q    <= ovf_d;
			dots_q   <= dots_d;
			flags_q  <= flags_d;
			pend_v_q <= pend_v_d;
			pend_c_q <= pend_c_d;
		end
	end

endmodule

// File: src/ctlex_queue.sv
`timescale 1ns / 1ps

module ctlex_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ctlex_pkg::rec_t push_rec,
	output logic            full,
	input  logic            pop,
	output ctlex_pkg::rec_t pop_rec,
	output logic            empty
);

	ctlex_pkg::rec_t                  slot_q [ctlex_pkg::QUEUE_DEPTH];
	logic [ctlex_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [ctlex_pkg::QCNT_W-1:0]     cnt_q;

	assign full    = cnt_q == ctlex_pkg::QCNT_W'(ctlex_pkg::QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign pop_rec = slot_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_rec;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + ctlex_pkg::QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + ctlex_pkg::QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + ctlex_pkg::QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - ctlex_pkg::QCNT_W'(1);
		end
	end

endmodule

// File: src/ctlex_back.sv
`timescale 1ns / 1ps

module ctlex_back #(
	parameter int MAX_TOKEN_LEN = ctlex_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	output logic            pop,
	input  ctlex_pkg::rec_t pop_rec,
	input  logic            empty,
	ctlex_token_if.source   token_out
);

	localparam int IDX_W = $clog2(MAX_TOKEN_LEN);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PRE_P  = 3'd1;
	localparam logic [2:0] ST_PRE_C  = 3'd2;
	localparam logic [2:0] ST_APPEND = 3'd3;
	localparam logic [2:0] ST_FL_RD  = 3'd4;
	localparam logic [2:0] ST_FL_EM  = 3'd5;
	localparam logic [2:0] ST_SINGLE = 3'd6;
	localparam logic [2:0] ST_POST   = 3'd7;

	// Phase order: held op, pair char, append, flush, single, post op
	localparam logic [2:0] PH_PRE_C  = 3'd1;
	localparam logic [2:0] PH_APPEND = 3'd2;
	localparam logic [2:0] PH_FLUSH  = 3'd3;
	localparam logic [2:0] PH_SINGLE = 3'd4;
	localparam logic [2:0] PH_POST   = 3'd5;
	localparam logic [2:0] PH_END    = 3'd6;

	logic [2:0]                  st_q, st_d;
	ctlex_pkg::rec_t             rec_q;
	logic [ctlex_pkg::LEN_W-1:0] k_q;
	logic [ctlex_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]                  rd_q;
	logic [7:0]                  store_mem [MAX_TOKEN_LEN];

	logic       out_valid_q;
	logic [2:0] out_cls_q;
	logic [7:0] out_char_q;
	logic       out_end_q;
	logic       out_run_q;

	logic [5:0] has, em;
	logic       out_free, capped, emit_st, fire, fl_last;
	logic [2:0] ld_cls;
	logic [7:0] ld_char;
	logic       ld_end, ld_later;

	function automatic logic [5:0] phases(ctlex_pkg::rec_t r);
		return {r.post_valid, r.single_valid, r.flush_valid, r.app_valid, r.pair,
			r.pre_valid};
	endfunction

	// First phase at or after start that has work
	function automatic logic [2:0] next_from(logic [5:0] h, logic [2:0] start);
		logic [2:0] s;
		s = ST_IDLE;
		for (int i = 5; i >= 0; i--) begin
			if (i >= int'(start) && h[i]) begin
				unique case (i)
					0:       s = ST_PRE_P;
					1:       s = ST_PRE_C;
					2:       s = ST_APPEND;
					3:       s = ST_FL_RD;
					4:       s = ST_SINGLE;
					default: s = ST_POST;
				endcase
			end
		end
		return s;
	endfunction

	assign has      = phases(rec_q);
	assign em       = has & ~(6'b1 << PH_APPEND);
	assign out_free = !out_valid_q || token_out.ready;
	assign capped   = cnt_q >= ctlex_pkg::CNT_W'(ctlex_pkg::MAX_RESULTS);
	assign emit_st  = st_q == ST_PRE_P || st_q == ST_PRE_C || st_q == ST_FL_EM ||
		st_q == ST_SINGLE || st_q == ST_POST;
	assign fire     = emit_st && (capped || out_free);
	assign fl_last  = (k_q + ctlex_pkg::LEN_W'(1)) == rec_q.flush_len;
	assign pop      = (st_q == ST_IDLE) && !empty;

	// Result payload and next state for the current phase
	always_comb begin
		ld_cls   = ctlex_pkg::CLS_OPER;
		ld_char  = rec_q.in_char;
		ld_end   = 1'b1;
		ld_later = 1'b0;
		st_d     = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (!empty)
					st_d = next_from(phases(pop_rec), 3'd0);
			end
			ST_PRE_P: begin
				ld_char  = rec_q.pre_char;
				ld_end   = !rec_q.pair;
				ld_later = |(em >> PH_PRE_C);
				if (fire)
					st_d = next_from(has, PH_PRE_C);
			end
			ST_PRE_C: begin
				ld_later = |(em >> PH_APPEND);
				if (fire)
					st_d = next_from(has, PH_APPEND);
			end
			ST_APPEND: begin
				st_d = next_from(has, PH_FLUSH);
			end
			ST_FL_RD: begin
				st_d = ST_FL_EM;
			end
			ST_FL_EM: begin
				ld_cls   = rec_q.flush_cls;
				ld_char  = rd_q;
				ld_end   = fl_last;
				ld_later = !fl_last || |(em >> PH_SINGLE);
				if (fire)
					st_d = fl_last ? next_from(has, PH_SINGLE) : ST_FL_RD;
			end
			ST_SINGLE: begin
				ld_cls   = rec_q.single_cls;
				ld_later = |(em >> PH_POST);
				if (fire)
					st_d = next_from(has, PH_POST);
			end
			ST_POST: begin
				if (fire)
					st_d = next_from(has, PH_END);
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			k_q   <= '0;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (pop) begin
				k_q   <= '0;
				cnt_q <= '0;
			end else begin
				if (fire && !capped)
					cnt_q <= cnt_q + ctlex_pkg::CNT_W'(1);
				if (fire && st_q == ST_FL_EM)
					k_q <= k_q + ctlex_pkg::LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= pop_rec;
	end

	// Word store
	always_ff @(posedge clk) begin
		if (st_q == ST_APPEND)
			store_mem[rec_q.app_idx[IDX_W-1:0]] <= rec_q.in_char;
		if (st_q == ST_FL_RD)
			rd_q <= store_mem[k_q[IDX_W-1:0]];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire && !capped)
			out_valid_q <= 1'b1;
		else if (token_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire && !capped) begin
			out_cls_q  <= ld_cls;
			out_char_q <= ld_char;
			out_end_q  <= ld_end;
			out_run_q  <= !ld_later ||
				cnt_q == ctlex_pkg::CNT_W'(ctlex_pkg::MAX_RESULTS - 1);
		end
	end

	assign token_out.valid       = out_valid_q;
	assign token_out.token_class = out_cls_q;
	assign token_out.token_char  = out_char_q;
	assign token_out.token_end   = out_end_q;
	assign token_out.run_end     = out_run_q;

	// Checks
	a_fl_idx: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FL_EM |-> k_q < rec_q.flush_len)
		else $error("flush index past word length");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ctlex_pkg::CNT_W'(ctlex_pkg::MAX_RESULTS))
		else $error("result count above cap");

	a_fl_seq: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FL_EM |-> $past(st_q) == ST_FL_RD || $past(st_q) == ST_FL_EM)
		else $error("flush emit without store read");

	a_app: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_APPEND |=> st_q != ST_APPEND)
		else $error("append phase repeated");

endmodule

// File: src/c_token_lexer_top.sv
`timescale 1ns / 1ps

// Each byte's command record passes through the queue into the back end, which works
// through its phases one record at a time; every result is registered at the output,
// and each word character is first read from the word store (store read, then output
// register). The front end takes new bytes while the queue is not full.
// Reset (arst_n low) clears all control state; the word store is not cleared.

module c_token_lexer_top #(
	parameter int MAX_TOKEN_LEN = ctlex_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ctlex_char_if.sink    char_in,
	ctlex_token_if.source token_out
);

	logic            push, full, pop, empty;
	ctlex_pkg::rec_t push_rec, pop_rec;

	ctlex_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_in),
		.push     (push),
		.push_rec (push_rec),
		.full     (full)
	);

	ctlex_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (empty)
	);

	ctlex_back #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_rec   (pop_rec),
		.empty     (empty),
		.token_out (token_out)
	);

endmodule

// File: tb/sv/tb_c_token_lexer_top.sv
`timescale 1ns / 1ps

module tb_c_token_lexer_top;

	localparam int TOKEN_LEN   = ctlex_pkg::MAX_TOKEN_LEN_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_CHARS = 125;

	// One character of an emitted token
	typedef struct packed {
		logic [2:0] cls;
		logic [7:0] ch;
		logic       last_char;
		logic       burst_end;
	} tok_t;

	// Tracks lexer state, predicts token bursts and checks the output stream
	class lexer_tracker;
		string        kw_words[8];
		logic [7:0]   word_buf[TOKEN_LEN];
		int           word_len;
		bit           word_ovf;
		int           dot_cnt;
		logic [10:0]  cand;
		logic [7:0]   held_op;
		bit           held_valid;
		tok_t         burst[$];
		tok_t         due_tokens[$];
		int           errors;
		int           chars_seen;
		int           texts_seen;
		int           tokens_seen;
		logic [7:0]   classes_seen;

		function new();
			kw_words = '{"int", "char", "float", "double", "if", "else", "while", "for"};
			restart_word();
			held_op = '0;
			held_valid = 1'b0;
			errors = 0;
			chars_seen = 0;
			texts_seen = 0;
			tokens_seen = 0;
			classes_seen = '0;
		endfunction

		function void restart_word();
			word_len = 0;
			word_ovf = 1'b0;
			dot_cnt = 0;
			cand = '1;
		endfunction

		function bit blank(logic [7:0] c);
			return c == ctlex_pkg::CH_SPACE || c == ctlex_pkg::CH_NUL ||
				(c >= ctlex_pkg::CH_TAB && c <= ctlex_pkg::CH_CR);
		endfunction

		function bit digit_ch(logic [7:0] c);
			return c >= ctlex_pkg::CH_ZERO && c <= ctlex_pkg::CH_NINE;
		endfunction

		function bit word_start_ch(logic [7:0] c);
			return (c >= ctlex_pkg::CH_UP_A && c <= ctlex_pkg::CH_UP_Z) ||
				(c >= ctlex_pkg::CH_LO_A && c <= ctlex_pkg::CH_LO_Z) ||
				c == ctlex_pkg::CH_UNDER;
		endfunction

		function bit op_lead(logic [7:0] c);
			return c == ctlex_pkg::CH_LT || c == ctlex_pkg::CH_GT ||
				c == ctlex_pkg::CH_BANG || c == ctlex_pkg::CH_PLUS ||
				c == ctlex_pkg::CH_MINUS || c == ctlex_pkg::CH_EQ ||
				c == ctlex_pkg::CH_STAR || c == ctlex_pkg::CH_SLASH ||
				c == ctlex_pkg::CH_PCT;
		endfunction

		// Punctuation that always stands alone; returns its class through cls
		function bit lone_token(logic [7:0] c, output logic [2:0] cls);
			cls = ctlex_pkg::CLS_SEP;
			if (c == ctlex_pkg::CH_SEMI || c == ctlex_pkg::CH_COMMA ||
					c == ctlex_pkg::CH_QUOTE)
				return 1'b1;
			cls = ctlex_pkg::CLS_PAREN;
			if (c == ctlex_pkg::CH_LPAR || c == ctlex_pkg::CH_RPAR ||
					c == ctlex_pkg::CH_LBRK || c == ctlex_pkg::CH_RBRK)
				return 1'b1;
			cls = ctlex_pkg::CLS_BRACE;
			return c == ctlex_pkg::CH_LBRACE || c == ctlex_pkg::CH_RBRACE;
		endfunction

		function void push_tok(logic [2:0] cls, logic [7:0] ch, logic last);
			tok_t t;
			if (burst.size() >= ctlex_pkg::MAX_RESULTS)
				return;
			t.cls = cls;
			t.ch = ch;
			t.last_char = last;
			t.burst_end = 1'b0;
			burst.push_back(t);
		endfunction

		// Classify the collected word and emit it
		function void flush_word();
			logic [2:0] cls;
			bit kw;
			if (word_len == 0)
				return;
			cls = ctlex_pkg::CLS_UNKNOWN;
			kw = 1'b0;
			if (!word_ovf) begin
				for (int k = 0; k < 8; k++)
					if (cand[k] && kw_words[k].len() == word_len)
						kw = 1'b1;
				if (kw)
					cls = ctlex_pkg::CLS_KEYWORD;
				else if (cand[ctlex_pkg::FLAG_OPSTRT])
					cls = ctlex_pkg::CLS_OPER;
				else if (cand[ctlex_pkg::FLAG_NUMBER] && dot_cnt <= 1)
					cls = ctlex_pkg::CLS_NUMBER;
				else if (cand[ctlex_pkg::FLAG_IDENT])
					cls = ctlex_pkg::CLS_IDENT;
			end
			for (int i = 0; i < word_len; i++)
				push_tok(cls, word_buf[i], i == word_len - 1);
			restart_word();
		endfunction

		// Extend the word and narrow the candidate classes
		function void add_char(logic [7:0] c);
			int i;
			i = word_len;
			if (word_ovf || i >= TOKEN_LEN) begin
				word_ovf = 1'b1;
				return;
			end
			for (int k = 0; k < 8; k++)
				if (i >= kw_words[k].len() || 8'(kw_words[k][i]) != c)
					cand[k] = 1'b0;
			if (c == ctlex_pkg::CH_DOT) begin
				if (dot_cnt < 2)
					dot_cnt++;
			end else if (!digit_ch(c)) begin
				cand[ctlex_pkg::FLAG_NUMBER] = 1'b0;
			end
			if (i == 0) begin
				if (!word_start_ch(c))
					cand[ctlex_pkg::FLAG_IDENT] = 1'b0;
				if (!(c == ctlex_pkg::CH_AMP || c == ctlex_pkg::CH_BAR ||
						c == ctlex_pkg::CH_CARET))
					cand[ctlex_pkg::FLAG_OPSTRT] = 1'b0;
			end else if (!word_start_ch(c) && !digit_ch(c)) begin
				cand[ctlex_pkg::FLAG_IDENT] = 1'b0;
			end
			word_buf[i] = c;
			word_len = i + 1;
		endfunction

		function void lex_one(logic [7:0] c);
			logic [2:0] sc;
			if (blank(c)) begin
				flush_word();
			end else if (lone_token(c, sc)) begin
				flush_word();
				push_tok(sc, c, 1'b1);
			end else if (op_lead(c)) begin
				flush_word();
				held_op = c;
				held_valid = 1'b1;
			end else begin
				add_char(c);
			end
		endfunction

		// Accepted source byte: queue the token characters it releases
		function void note_char(logic [7:0] c, logic eot);
			logic [7:0] p;
			tok_t t;
			burst.delete();
			chars_seen++;
			if (eot)
				texts_seen++;
			if (held_valid) begin
				p = held_op;
				held_valid = 1'b0;
				held_op = '0;
				if (c == ctlex_pkg::CH_EQ ||
						(c == ctlex_pkg::CH_PLUS && p == ctlex_pkg::CH_PLUS) ||
						(c == ctlex_pkg::CH_MINUS && p == ctlex_pkg::CH_MINUS)) begin
					push_tok(ctlex_pkg::CLS_OPER, p, 1'b0);
					push_tok(ctlex_pkg::CLS_OPER, c, 1'b1);
				end else begin
					push_tok(ctlex_pkg::CLS_OPER, p, 1'b1);
					lex_one(c);
				end
			end else begin
				lex_one(c);
			end
			// end of text flushes a held operator, then the word
			if (eot) begin
				if (held_valid) begin
					push_tok(ctlex_pkg::CLS_OPER, held_op, 1'b1);
					held_valid = 1'b0;
					held_op = '0;
				end
				flush_word();
			end
			if (burst.size() > 0) begin
				t = burst.pop_back();
				t.burst_end = 1'b1;
				burst.push_back(t);
			end
			foreach (burst[i])
				due_tokens.push_back(burst[i]);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 200)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_token(logic [2:0] cls, logic [7:0] ch, logic te, logic re);
			tok_t want;
			tokens_seen++;
			if (due_tokens.size() == 0) begin
				report($sformatf("token char %h class %0d arrived with none pending", ch, cls));
				return;
			end
			want = due_tokens.pop_front();
			classes_seen[cls] = 1'b1;
			if (cls !== want.cls)
				report($sformatf("char %h: class %0d, want %0d", want.ch, cls, want.cls));
			if (ch !== want.ch)
				report($sformatf("token char %h, want %h", ch, want.ch));
			if (te !== want.last_char)
				report($sformatf("char %h: token_end %b, want %b", want.ch, te, want.last_char));
			if (re !== want.burst_end)
				report($sformatf("char %h: run_end %b, want %b", want.ch, re, want.burst_end));
		endtask
	endclass

	logic clk;
	logic arst_n;

	ctlex_char_if  char_bus();
	ctlex_token_if token_bus();

	c_token_lexer_top #(
		.MAX_TOKEN_LEN(TOKEN_LEN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_bus),
		.token_out(token_bus)
	);

	lexer_tracker sb;
	logic [7:0]   text_q[$];
	bit           eot_q[$];
	int           cycles;

	string op_chars    = "<>!+-=*/%";
	string lone_chars  = ";,'()[]{}";
	string opword_lead = "&|^";

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_c_token_lexer_top: errors");
			$finish;
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && token_bus.valid && token_bus.ready)
			sb.check_token(token_bus.token_class, token_bus.token_char,
				token_bus.token_end, token_bus.run_end);
	end

	function bit quiet_stretch();
		return sb.chars_seen >= 90 && sb.chars_seen < 130;
	endfunction

	task add_byte(logic [7:0] c, bit eot);
		text_q.push_back(c);
		eot_q.push_back(eot);
	endtask

	task add_text(string s, bit eot_last);
		for (int i = 0; i < s.len(); i++)
			add_byte(8'(s[i]), eot_last && i == s.len() - 1);
	endtask

	// Random whitespace or NUL
	task add_gap();
		int r;
		r = $urandom_range(0, 6);
		if (r == 0)
			add_byte(ctlex_pkg::CH_SPACE, 1'b0);
		else if (r == 1)
			add_byte(ctlex_pkg::CH_NUL, 1'b0);
		else
			add_byte(ctlex_pkg::CH_TAB + 8'(r - 2), 1'b0);
	endtask

	function logic [7:0] word_char();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return ctlex_pkg::CH_ZERO + 8'($urandom_range(0, 9));
		else if (r == 1)
			return ctlex_pkg::CH_UP_A + 8'($urandom_range(0, 25));
		else if (r == 2 && $urandom_range(0, 3) == 0)
			return ctlex_pkg::CH_UNDER;
		return ctlex_pkg::CH_LO_A + 8'($urandom_range(0, 25));
	endfunction

	// Word around the store size, often past it
	task add_long_word();
		int n;
		n = $urandom_range(TOKEN_LEN - 1, TOKEN_LEN + 8);
		add_byte(ctlex_pkg::CH_LO_A + 8'($urandom_range(0, 25)), 1'b0);
		for (int i = 1; i < n; i++)
			add_byte(word_char(), 1'b0);
		add_gap();
	endtask

	// One source byte transfer, with random idle cycles ahead of it
	task send_char(logic [7:0] c, logic eot);
		@(negedge clk);
		while (!quiet_stretch() && $urandom_range(0, 99) < 11) begin
			char_bus.valid <= 1'b0;
			@(negedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.source_char <= c;
		char_bus.end_of_text <= eot;
		do
			@(posedge clk);
		while (!char_bus.ready);
		sb.note_char(c, eot);
	endtask

	// Token side: random stalls plus one long hold-off
	task serve_tokens();
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sb.chars_seen >= 40) begin
				held = 1'b1;
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					token_bus.ready <= 1'b0;
					@(negedge clk);
				end
			end
			token_bus.ready <= quiet_stretch() || $urandom_range(0, 99) >= 11;
		end
	endtask

	initial begin
		int dir_count;
		int kind;
		int n;
		logic [7:0] p;

		char_bus.valid = 1'b0;
		char_bus.source_char = '0;
		char_bus.end_of_text = 1'b0;
		token_bus.ready = 1'b0;
		arst_n = 1'b0;
		sb = new();

		// Directed: punctuation, pair operators, number with dot, extreme bytes,
		// op-start word, lone dot, held operator flushed by end of text
		add_text("if(a>=1.5){b++;}", 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(ctlex_pkg::CH_NUL, 1'b0);
		add_text("&|',.", 1'b0);
		add_byte(ctlex_pkg::CH_MINUS, 1'b1);
		dir_count = text_q.size();

		// Random: mostly well-formed tokens, some noise
		add_long_word();
		while (text_q.size() < dir_count + RANDOM_CHARS) begin
			kind = $urandom_range(0, 13);
			case (kind)
				0: begin
					if ($urandom_range(0, 4) == 0) begin
						add_long_word();
					end else begin
						add_text(sb.kw_words[$urandom_range(0, 7)], 1'b0);
						if ($urandom_range(0, 3) == 0)
							add_byte(word_char(), 1'b0);
					end
				end
				1, 2: begin
					add_byte(($urandom_range(0, 4) == 0) ? ctlex_pkg::CH_UNDER :
						ctlex_pkg::CH_LO_A + 8'($urandom_range(0, 25)), 1'b0);
					n = $urandom_range(0, 6);
					for (int i = 0; i < n; i++)
						add_byte(word_char(), 1'b0);
				end
				3: begin
					n = $urandom_range(1, 5);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 5) == 0)
							add_byte(ctlex_pkg::CH_DOT, 1'b0);
						add_byte(ctlex_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
					end
				end
				4, 5: begin
					p = 8'(op_chars[$urandom_range(0, 8)]);
					add_byte(p, 1'b0);
					case ($urandom_range(0, 2))
						0: add_byte(ctlex_pkg::CH_EQ, 1'b0);
						1: if (p == ctlex_pkg::CH_PLUS || p == ctlex_pkg::CH_MINUS)
							add_byte(p, 1'b0);
						default: ;
					endcase
				end
				6: add_byte(8'(lone_chars[$urandom_range(0, 8)]), 1'b0);
				7: begin
					add_byte(8'(opword_lead[$urandom_range(0, 2)]), 1'b0);
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++)
						add_byte(8'($urandom_range(33, 126)), 1'b0);
				end
				8: begin
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++)
						add_byte(8'($urandom_range(0, 255)), 1'b0);
				end
				default: add_gap();
			endcase
			if (kind <= 3 || kind == 7)
				if ($urandom_range(0, 9) < 7)
					add_gap();
			if ($urandom_range(0, 11) == 0)
				eot_q[eot_q.size() - 1] = 1'b1;
		end
		eot_q[eot_q.size() - 1] = 1'b1;

		// Reset
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		fork
			serve_tokens();
		join_none

		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], eot_q[i]);
		@(negedge clk);
		char_bus.valid <= 1'b0;

		// Drain, then watch for stray tokens
		while (sb.due_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.due_tokens.size() != 0)
			sb.report($sformatf("%0d token chars never arrived", sb.due_tokens.size()));

		$display("run: %0d source bytes (%0d end-of-text marks), %0d token chars checked",
			sb.chars_seen, sb.texts_seen, sb.tokens_seen);
		$display("run: token classes seen %b, one %0d-cycle output hold-off",
			sb.classes_seen, HOLD_CYCLES);
		if (sb.errors == 0)
			$display("tb_c_token_lexer_top: clean");
		else
			$display("tb_c_token_lexer_top: errors");
		$finish;
	end

endmodule
